@@ hdl/kmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared constants, types and the matrix scan function for the keypad
// matrix scan and debounce core.
// ----------------------------------------------------------------------------
package kmsd_pkg;

	localparam int NUM_ROWS   = 4;
	localparam int NUM_COLS   = 5;
	localparam int MATRIX_W   = 20;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;
	localparam int CODE_W     = 6;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int EVENT_W    = 2;

	typedef logic [MATRIX_W-1:0] matrix_t;
	typedef logic [CODE_W-1:0]   code_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} key_event_t;

	typedef struct packed {
		code_t code;
		logic  mashed;
	} scan_t;

	typedef struct packed {
		logic       pad_mashed;
		logic       key_down;
		code_t      active_code;
		key_event_t key_event;
	} result_t;

	function automatic scan_t scan_matrix(input matrix_t m);
		scan_t            res;
		logic             found;
		logic             done;
		logic [ROW_W-1:0] row_part;
		logic [COL_W-1:0] col_part;
		logic             row_any;
		res      = '0;
		found    = 1'b0;
		done     = 1'b0;
		row_part = '0;
		col_part = '0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			row_any = 1'b0;
			for (int c = 0; c < NUM_COLS; c++) begin
				if (r * NUM_COLS + c < MATRIX_W) begin
					row_any = row_any | m[r * NUM_COLS + c];
				end
			end
			if (row_any && !done) begin
				if (found) begin
					res.mashed = 1'b1;
					done       = 1'b1;
				end else begin
					found    = 1'b1;
					row_part = ROW_W'(r + 1);
					for (int c = 0; c < NUM_COLS; c++) begin
						if (r * NUM_COLS + c < MATRIX_W) begin
							if (m[r * NUM_COLS + c]) begin
								if (col_part != '0) begin
									res.mashed = 1'b1;
								end
								col_part = col_part | COL_W'(c + 1);
							end
						end
					end
				end
			end
		end
		if (found && col_part != '0) begin
			res.code = {row_part, col_part};
		end else begin
			res.code = '0;
		end
		return res;
	endfunction

endpackage

@@ hdl/keypad_matrix_scan_debounce_core.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce_core
// Scans one key matrix snapshot per word, debounces over two samples and
// reports press and release events with the held key code.
// ----------------------------------------------------------------------------
// One snapshot word goes in, one result word comes out, at up to one word
// per clock when the output side is not stalled. An accepted word is held
// in the input register, then scanned and debounced on its way into the
// output register, from which the result word is offered until taken. The
// debounce state advances only when a result is written to the output
// register, so stalls on either side never lose or repeat a word.
module keypad_matrix_scan_debounce_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// key_matrix[19:0], zero pad
	input  logic [kmsd_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// key_event[1:0], active_code[7:2], key_down[8], pad_mashed[9], zero pad
	output logic [kmsd_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic              valid_s1;
	kmsd_pkg::matrix_t matrix_s1;
	logic              out_valid_q;
	kmsd_pkg::result_t result_q;
	kmsd_pkg::code_t   sample_now_q;
	kmsd_pkg::code_t   held_code_q;
	logic              held_flag_q;

	logic              out_free;
	logic              advance;
	kmsd_pkg::scan_t   scan;
	kmsd_pkg::result_t result_d;
	kmsd_pkg::code_t   held_code_d;
	logic              held_flag_d;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(kmsd_pkg::OUT_DATA_W - $bits(kmsd_pkg::result_t)){1'b0}}, result_q};

	always_comb begin
		scan        = kmsd_pkg::scan_matrix(matrix_s1);
		held_code_d = held_code_q;
		held_flag_d = held_flag_q;
		result_d.key_event = kmsd_pkg::EV_NONE;
		if (held_flag_q && (scan.mashed || (scan.code == '0 && sample_now_q == '0))) begin
			held_flag_d        = 1'b0;
			result_d.key_event = kmsd_pkg::EV_RELEASE;
		end else if (!held_flag_q && scan.code != '0 && scan.code == sample_now_q) begin
			held_code_d        = scan.code;
			held_flag_d        = 1'b1;
			result_d.key_event = kmsd_pkg::EV_PRESS;
		end
		result_d.active_code = held_code_d;
		result_d.key_down    = held_flag_d;
		result_d.pad_mashed  = scan.mashed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			sample_now_q    <= '0;
			held_code_q     <= '0;
			held_flag_q     <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q     <= 1'b1;
				sample_now_q    <= scan.code;
				held_code_q     <= held_code_d;
				held_flag_q     <= held_flag_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			matrix_s1 <= s_tdata[kmsd_pkg::MATRIX_W-1:0];
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

endmodule

@@ hdl/kmsd_checker.sv @@
// ----------------------------------------------------------------------------
// kmsd_checker
// Port-level checks on the result stream of the keypad scan core.
// ----------------------------------------------------------------------------
module kmsd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kmsd_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [1:0] ev;
	assign ev = m_tdata[1:0];

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ev != 2'd3))
		else $error("invalid key event code");

	a_press_down: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ev == kmsd_pkg::EV_PRESS) |-> (m_tdata[8] && m_tdata[7:2] != '0))
		else $error("press without held nonzero code");

	a_release_up: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ev == kmsd_pkg::EV_RELEASE) |-> !m_tdata[8])
		else $error("release with key still down");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result word changed");

endmodule

bind keypad_matrix_scan_debounce_core kmsd_checker u_kmsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
